### sv/isms_pkg.sv
// Shared types and constants for the interval set merge table.
package isms_pkg;

  localparam int unsigned MAX_RANGES_DEF = 16;

  typedef enum logic [1:0] {
    CMD_PUT      = 2'd0,
    CMD_CONTAINS = 2'd1,
    CMD_REWIND   = 2'd2,
    CMD_ADVANCE  = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_OVFL  = 2'd3;

  // per-cell operation broadcast by the sequencer
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_MRG  = 2'd2,
    OP_ABS  = 2'd3
  } cel_op_t;

  typedef struct packed {
    cel_op_t     op;
    logic [31:0] s;
    logic [31:0] len;
    logic [32:0] ne;
  } cel_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_MERGE = 3'b100
  } state_t;

endpackage

### sv/isms_if.sv
// Valid/ready channel interfaces for request and response beats.
interface isms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] range_start;
  logic [31:0] range_length;

  modport source (output valid, command, range_start, range_length, input ready);
  modport sink   (input valid, command, range_start, range_length, output ready);
endinterface

interface isms_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [31:0] cur_start;
  logic [31:0] cur_length;
  logic        is_empty;
  logic [4:0]  stored_count;

  modport source (output valid, status, hit, cur_start, cur_length, is_empty, stored_count,
                  input ready);
  modport sink   (input valid, status, hit, cur_start, cur_length, is_empty, stored_count,
                  output ready);
endinterface

### sv/interval_set_merge_table_top.sv
// Top level of the interval set merge table: sequencer and row of slots.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  in_bus   | in  | valid / ready | command, range_start, range_length
//  out_bus  | out | valid / ready | status, hit, cur_start, cur_length,
//           |     |               | is_empty, stored_count
//
// One request beat in flight. Contains, rewind, advance and rejected or
// inserting puts respond from S_EVAL; a put that coalesces stored ranges
// folds into the first overlapping slot in S_EVAL, absorbs one further
// neighbor per shift step of the slot row in S_MERGE, and responds once no
// neighbor is left. Synchronous active-low reset clears state, count, cursor
// and the valid flags; slot contents are don't-care until written. A stall
// on out_bus holds the response register and keeps in_bus not ready.
module interval_set_merge_table_top import isms_pkg::*; #(
  parameter int unsigned MAX_RANGES = MAX_RANGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  isms_in_if.sink    in_bus,
  isms_out_if.source out_bus
);

  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned IW = $clog2(MAX_RANGES);

  state_t      state_r, state_nxt;
  logic [1:0]  cmd_r;
  logic [31:0] s_r, len_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic        cv_r, cv_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  o_status_r, o_status_nxt;
  logic        o_hit_r, o_hit_nxt;
  logic [31:0] o_cs_r, o_cs_nxt, o_cl_r, o_cl_nxt;

  cel_ctl_t    ctl;
  logic [32:0] ne;
  logic        ovf;

  logic [31:0] c_st  [MAX_RANGES];
  logic [31:0] c_len [MAX_RANGES];
  logic [32:0] c_end [MAX_RANGES];
  logic [MAX_RANGES-1:0] c_vld, c_blw, c_ovl, c_hit, c_cand;

  logic [CW-1:0] adv_n;

  assign ne  = {1'b0, s_r} + {1'b0, len_r};
  assign ovf = ne[32] && (ne[31:0] != 32'd0);
  assign adv_n = CW'(cur_r) + CW'(1);

  // slot row: each slot sees its left and right neighbors only
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    assign c_vld[i] = (CW'(i) < count_r);
    if (i == 0) begin : g_first
      if (MAX_RANGES > 1) begin : g_r
        isms_cell u_cell (
          .clk, .ctl, .vld(c_vld[i]), .left_blw(1'b1),
          .l_st(32'd0), .l_len(32'd0),
          .r_vld(c_vld[i+1]), .r_st(c_st[i+1]), .r_len(c_len[i+1]), .r_end(c_end[i+1]),
          .st(c_st[i]), .len(c_len[i]), .end_o(c_end[i]),
          .blw(c_blw[i]), .ovl(c_ovl[i]), .hit(c_hit[i]), .cand(c_cand[i]));
      end
    end else if (i == MAX_RANGES - 1) begin : g_last
      isms_cell u_cell (
        .clk, .ctl, .vld(c_vld[i]), .left_blw(c_blw[i-1]),
        .l_st(c_st[i-1]), .l_len(c_len[i-1]),
        .r_vld(1'b0), .r_st(32'd0), .r_len(32'd0), .r_end(33'd0),
        .st(c_st[i]), .len(c_len[i]), .end_o(c_end[i]),
        .blw(c_blw[i]), .ovl(c_ovl[i]), .hit(c_hit[i]), .cand(c_cand[i]));
    end else begin : g_mid
      isms_cell u_cell (
        .clk, .ctl, .vld(c_vld[i]), .left_blw(c_blw[i-1]),
        .l_st(c_st[i-1]), .l_len(c_len[i-1]),
        .r_vld(c_vld[i+1]), .r_st(c_st[i+1]), .r_len(c_len[i+1]), .r_end(c_end[i+1]),
        .st(c_st[i]), .len(c_len[i]), .end_o(c_end[i]),
        .blw(c_blw[i]), .ovl(c_ovl[i]), .hit(c_hit[i]), .cand(c_cand[i]));
    end
  end

  assign in_bus.ready         = (state_r == S_IDLE) && !ov_r;
  assign out_bus.valid        = ov_r;
  assign out_bus.status       = o_status_r;
  assign out_bus.hit          = o_hit_r;
  assign out_bus.cur_start    = o_cs_r;
  assign out_bus.cur_length   = o_cl_r;
  assign out_bus.is_empty     = (count_r == '0);
  assign out_bus.stored_count = 5'(count_r);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    cur_nxt      = cur_r;
    cv_nxt       = cv_r;
    ov_nxt       = ov_r;
    o_status_nxt = o_status_r;
    o_hit_nxt    = o_hit_r;
    o_cs_nxt     = o_cs_r;
    o_cl_nxt     = o_cl_r;
    ctl.op       = OP_HOLD;
    ctl.s        = s_r;
    ctl.len      = len_r;
    ctl.ne       = ne;

    if (ov_r && out_bus.ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_bus.valid && in_bus.ready) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt    = S_IDLE;
        ov_nxt       = 1'b1;
        o_status_nxt = ST_OK;
        o_hit_nxt    = 1'b0;
        o_cs_nxt     = 32'd0;
        o_cl_nxt     = 32'd0;
        unique case (cmd_t'(cmd_r))
          CMD_PUT: begin
            if (ovf) begin
              o_status_nxt = ST_OVFL;
            end else if (len_r == 32'd0) begin
              o_status_nxt = ST_OK;
            end else if (|c_ovl) begin
              // fold into the first overlapping slot, then absorb neighbors
              ctl.op    = OP_MRG;
              cv_nxt    = 1'b0;
              ov_nxt    = 1'b0;
              state_nxt = S_MERGE;
            end else if (count_r == CW'(MAX_RANGES)) begin
              o_status_nxt = ST_FULL;
            end else begin
              ctl.op    = OP_INS;
              count_nxt = count_r + CW'(1);
              cv_nxt    = 1'b0;
            end
          end
          CMD_CONTAINS: begin
            if (ovf) o_status_nxt = ST_OVFL;
            else     o_hit_nxt    = |c_hit;
          end
          CMD_REWIND: begin
            cur_nxt = '0;
            cv_nxt  = (count_r != '0);
            if (count_r != '0) begin
              o_cs_nxt = c_st[0];
              o_cl_nxt = c_len[0];
            end else begin
              o_status_nxt = ST_END;
            end
          end
          CMD_ADVANCE: begin
            if (!cv_r || adv_n >= count_r) begin
              o_status_nxt = ST_END;
            end else begin
              cur_nxt  = IW'(adv_n);
              o_cs_nxt = c_st[IW'(adv_n)];
              o_cl_nxt = c_len[IW'(adv_n)];
            end
          end
          default: ;
        endcase
      end
      S_MERGE: begin
        if (|c_cand) begin
          ctl.op    = OP_ABS;
          count_nxt = count_r - CW'(1);
        end else begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cur_r   <= '0;
      cv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
      cv_r    <= cv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      cmd_r <= in_bus.command;
      s_r   <= in_bus.range_start;
      len_r <= in_bus.range_length;
    end
    o_status_r <= o_status_nxt;
    o_hit_r    <= o_hit_nxt;
    o_cs_r     <= o_cs_nxt;
    o_cl_r     <= o_cl_nxt;
  end

endmodule

### sv/isms_cell.sv
// One table slot: holds a range and trades it with its neighbors.
module isms_cell import isms_pkg::*; (
  input  logic        clk,
  input  cel_ctl_t    ctl,
  input  logic        vld,
  input  logic        left_blw,
  input  logic [31:0] l_st,
  input  logic [31:0] l_len,
  input  logic        r_vld,
  input  logic [31:0] r_st,
  input  logic [31:0] r_len,
  input  logic [32:0] r_end,
  output logic [31:0] st,
  output logic [31:0] len,
  output logic [32:0] end_o,
  output logic        blw,
  output logic        ovl,
  output logic        hit,
  output logic        cand
);

  logic [31:0] st_r, st_nxt, len_r, len_nxt;
  logic        mk_r, ak_r;
  logic        wr_r, wr_nxt;
  logic [32:0] end_w, end_m, me, span;
  logic [31:0] ms;
  logic        pos, aft;

  assign end_w = {1'b0, st_r} + {1'b0, len_r};
  // merged span of 2^32 wraps the stored length; keep the true end while absorbing
  assign end_m = wr_r ? 33'h1_0000_0000 : end_w;
  assign blw   = vld && (end_w < {1'b0, ctl.s});
  assign ovl   = vld && !blw && ({1'b0, st_r} <= ctl.ne);
  assign hit   = vld && (ctl.s >= st_r) && (ctl.ne <= end_w);
  assign pos   = left_blw && !blw;   // first slot not wholly below the new range
  assign aft   = !left_blw;
  assign cand  = mk_r && r_vld && ({1'b0, r_st} <= end_m);

  assign st    = st_r;
  assign len   = len_r;
  assign end_o = end_w;

  always_comb begin
    st_nxt  = st_r;
    len_nxt = len_r;
    wr_nxt  = wr_r;
    ms      = st_r;
    me      = end_w;
    span    = '0;
    case (ctl.op)
      OP_INS: begin
        if (pos) begin
          st_nxt  = ctl.s;
          len_nxt = ctl.len;
        end else if (aft) begin
          st_nxt  = l_st;
          len_nxt = l_len;
        end
      end
      OP_MRG: begin
        wr_nxt = 1'b0;
        if (pos) begin
          ms      = (ctl.s < st_r) ? ctl.s : st_r;
          me      = (ctl.ne > end_w) ? ctl.ne : end_w;
          span    = me - {1'b0, ms};
          st_nxt  = ms;
          len_nxt = span[31:0];
          wr_nxt  = span[32];
        end
      end
      OP_ABS: begin
        if (mk_r) begin
          me      = (r_end > end_m) ? r_end : end_m;
          span    = me - {1'b0, st_r};
          len_nxt = span[31:0];
          wr_nxt  = span[32];
        end else if (ak_r) begin
          st_nxt  = r_st;
          len_nxt = r_len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    len_r <= len_nxt;
    wr_r  <= wr_nxt;
    if (ctl.op == OP_MRG) begin
      mk_r <= pos;
      ak_r <= aft;
    end
  end

endmodule
